[sv/fdct_pkg.sv]
package fdct_pkg;

    localparam int BLOCK_DIM  = 8;
    localparam int NCELLS     = BLOCK_DIM * BLOCK_DIM;
    localparam int IDX_W      = $clog2(BLOCK_DIM);
    localparam int CNT_W      = $clog2(NCELLS);
    localparam int CENTRE     = 128;
    localparam int ROW_SHIFT  = 8;
    localparam int COL_SHIFT  = 20;
    localparam int ACC_W      = 40;
    // fetch, one hop per cell, product and accumulate after the last operand
    localparam int LAST_TICK  = 2 * BLOCK_DIM + 1;
    localparam int TICK_W     = $clog2(LAST_TICK + 1);

    typedef logic signed [15:0] coef_t;
    typedef logic signed [15:0] rowv_t;

    // Q1.14 value of 0.5 * a(u) * cos((2i+1)u pi/16)
    function automatic coef_t basis(input logic [IDX_W-1:0] u, input logic [IDX_W-1:0] i);
        logic [4:0] k;
        logic [3:0] m;
        coef_t mag;
        begin
            k = 5'((({1'b0, i, 1'b0} + 5'd1) * u));
            if (k > 5'd16)
                k = 5'd0 - k;
            m = (k > 5'd8) ? 4'(5'd16 - k) : k[3:0];
            case (m)
                4'd0:    mag = 16'sd8192;
                4'd1:    mag = 16'sd8035;
                4'd2:    mag = 16'sd7568;
                4'd3:    mag = 16'sd6811;
                4'd4:    mag = 16'sd5793;
                4'd5:    mag = 16'sd4551;
                4'd6:    mag = 16'sd3135;
                4'd7:    mag = 16'sd1598;
                default: mag = 16'sd0;
            endcase
            if (u == '0)
                basis = 16'sd5793;
            else if (k > 5'd8)
                basis = -mag;
            else
                basis = mag;
        end
    endfunction

    // round halves away from zero, then shift
    function automatic logic signed [ACC_W-1:0] round_shift(
        input logic signed [ACC_W-1:0] acc, input int sh);
        logic [ACC_W-1:0] mag;
        begin
            mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
            mag = (mag + (ACC_W'(1) << (sh - 1))) >> sh;
            round_shift = acc[ACC_W-1] ? -$signed(mag) : $signed(mag);
        end
    endfunction

    typedef struct packed {
        logic                     clear;
        logic                     en;
        logic [IDX_W-1:0]         step;
    } mac_ctrl_t;

endpackage

[sv/fdct_cell.sv]
// one multiply-accumulate cell of the chain; operand and control move to the next cell each cycle
module fdct_cell
    import fdct_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [IDX_W-1:0]          freq,
    input  mac_ctrl_t                 ctrl_in,
    input  rowv_t                     din,
    output mac_ctrl_t                 ctrl_out,
    output rowv_t                     dout,
    output logic signed [ACC_W-1:0]   acc
);
    mac_ctrl_t                ctrl_reg;
    rowv_t                    d_reg;
    logic signed [31:0]       prod_reg;
    logic                     pv_reg;
    logic                     pclr_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    coef_t                    c;

    assign c = basis(freq, ctrl_in.step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
            pv_reg   <= 1'b0;
            pclr_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
            pv_reg   <= ctrl_in.en;
            pclr_reg <= ctrl_in.clear;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg    <= din;
        prod_reg <= 32'(din) * 32'(c);
        if (pv_reg)
            acc_reg <= (pclr_reg ? '0 : acc_reg) + ACC_W'(prod_reg);
    end

    assign ctrl_out = ctrl_reg;
    assign dout     = d_reg;
    assign acc      = acc_reg;
endmodule

[sv/forward_dct_8x8_unit.sv]
// channel  | dir | tdata bits                        | tuser
// s_axis   | in  | [7:0] pixel                       | -
// m_axis   | out | [11:0] coefficient, [15:12] zero  | - (tlast = last_of_block)
// 64 pixels are loaded, one per transaction; tready then stays low through both passes and the read-out.
// the row pass and the column pass each run 8 lines: 8 operands enter the chain of
// eight MAC cells, then the sums drain through it; the column pass waits for the
// last row write-back. 64 coefficients then load into the output register, one
// per cycle; a sink stall holds the read-out.
// Reset clears control state; stores are written first.
module forward_dct_8x8_unit
    import fdct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [11:0] coefficient, [15:12] zero
    output logic        m_axis_tlast
);
    typedef enum logic [3:0] {
        S_LOAD = 4'b0001,
        S_ROW  = 4'b0010,
        S_COL  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        load_reg;
    logic [IDX_W-1:0]        line_reg;   // row or column index
    logic [TICK_W-1:0]       tick_reg;   // 0..7 feed, then drain
    logic [CNT_W-1:0]        emit_reg;

    logic signed [7:0]       samp_mem [NCELLS];
    rowv_t                   rowp_mem [NCELLS];   // row sums, later the coefficients

    rowv_t                   chain [BLOCK_DIM+1];
    mac_ctrl_t               ctl   [BLOCK_DIM+1];
    logic signed [ACC_W-1:0] accs  [BLOCK_DIM];
    rowv_t                   feed_reg;
    logic                    fv_reg;
    logic [IDX_W-1:0]        fstep_reg;
    logic                    fclr_reg;

    logic signed [ACC_W-1:0] hold [BLOCK_DIM];
    logic                    wb_reg;
    logic                    wcol_reg;
    logic [IDX_W-1:0]        wbi_reg;
    logic [IDX_W-1:0]        wline_reg;
    logic signed [ACC_W-1:0] wr;
    rowv_t                   wdata;
    logic [CNT_W-1:0]        waddr;

    logic                    s_fire;
    logic                    line_done;
    logic                    col_stall;
    logic                    run;
    logic                    out_load;
    logic [15:0]             out_data_reg;
    logic                    out_last_reg;
    logic                    ovalid_reg;

    assign s_axis_tready = (state_reg == S_LOAD);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign line_done     = (tick_reg == TICK_W'(LAST_TICK));
    // the column pass starts once the last row is in the store
    assign col_stall     = wb_reg && !wcol_reg;
    assign run           = (state_reg == S_ROW) || (state_reg == S_COL && !col_stall);
    assign out_load      = (state_reg == S_OUT) && (!ovalid_reg || m_axis_tready);

    // rounding and saturation of one held sum per cycle
    always_comb
    begin
        if (wcol_reg)
        begin
            wr    = round_shift(hold[wbi_reg], COL_SHIFT);
            wdata = (wr > ACC_W'(2047)) ? 16'sd2047 :
                    (wr < -ACC_W'(2048)) ? -16'sd2048 : wr[15:0];
            waddr = {wbi_reg, wline_reg};
        end
        else
        begin
            wr    = round_shift(hold[wbi_reg], ROW_SHIFT);
            wdata = (wr > ACC_W'(32767)) ? 16'sd32767 :
                    (wr < -ACC_W'(32768)) ? -16'sd32768 : wr[15:0];
            waddr = {wline_reg, wbi_reg};
        end
    end

    // stores: registered reads only
    always_ff @(posedge clk)
    begin
        if (s_fire)
            samp_mem[load_reg] <= 8'(s_axis_tdata - 8'(CENTRE));
        if (wb_reg)
            rowp_mem[waddr] <= wdata;
        if (state_reg == S_ROW)
            feed_reg <= 16'(samp_mem[{line_reg, tick_reg[IDX_W-1:0]}]);
        else
            feed_reg <= rowp_mem[{tick_reg[IDX_W-1:0], line_reg}];
        // column 7 write-back stays ahead of the read-out of its entries
        if (out_load)
        begin
            out_data_reg <= {4'd0, rowp_mem[emit_reg][11:0]};
            out_last_reg <= (emit_reg == CNT_W'(NCELLS-1));
        end
        fstep_reg <= tick_reg[IDX_W-1:0];
        fclr_reg  <= (tick_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_ROW || state_reg == S_COL) && line_done)
            for (int v = 0; v < BLOCK_DIM; v++)
                hold[v] <= accs[v];
    end

    assign ctl[0]   = '{clear: fclr_reg, en: fv_reg, step: fstep_reg};
    assign chain[0] = feed_reg;

    genvar g;
    generate
        for (g = 0; g < BLOCK_DIM; g++)
        begin : g_cell
            fdct_cell u_cell (
                .clk(clk), .rst_n(rst_n), .freq(IDX_W'(g)),
                .ctrl_in(ctl[g]), .din(chain[g]),
                .ctrl_out(ctl[g+1]), .dout(chain[g+1]), .acc(accs[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD: if (s_fire && load_reg == CNT_W'(NCELLS-1)) state_next = S_ROW;
            S_ROW:  if (line_done && line_reg == IDX_W'(BLOCK_DIM-1)) state_next = S_COL;
            S_COL:  if (line_done && line_reg == IDX_W'(BLOCK_DIM-1)) state_next = S_OUT;
            S_OUT:  if (out_load && emit_reg == CNT_W'(NCELLS-1)) state_next = S_LOAD;
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD; load_reg <= '0; line_reg <= '0; tick_reg <= '0;
            emit_reg <= '0; fv_reg <= 1'b0; wb_reg <= 1'b0; wcol_reg <= 1'b0;
            wbi_reg <= '0; wline_reg <= '0; ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (s_fire)
                load_reg <= load_reg + 1'b1;
            fv_reg <= run && (tick_reg < TICK_W'(BLOCK_DIM));
            if (run)
            begin
                if (line_done)
                begin
                    tick_reg <= '0;
                    line_reg <= line_reg + 1'b1;
                end
                else
                    tick_reg <= tick_reg + 1'b1;
            end
            // eight sums of the finished line go to the store, one per cycle
            if ((state_reg == S_ROW || state_reg == S_COL) && line_done)
            begin
                wb_reg    <= 1'b1;
                wbi_reg   <= '0;
                wline_reg <= line_reg;
                wcol_reg  <= (state_reg == S_COL);
            end
            else if (wb_reg)
            begin
                wbi_reg <= wbi_reg + 1'b1;
                if (wbi_reg == IDX_W'(BLOCK_DIM-1))
                    wb_reg <= 1'b0;
            end
            if (out_load)
            begin
                ovalid_reg <= 1'b1;
                emit_reg   <= emit_reg + 1'b1;
            end
            else if (m_axis_tready)
                ovalid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
endmodule
